@@ design/btp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// btp_pkg
// Shared types and constants of the binary thinning pass core.
// ----------------------------------------------------------------------------

package btp_pkg;

  localparam int unsigned IMG_W_W             = 11;
  localparam int unsigned IMG_H_W             = 12;
  localparam int unsigned CFG_DATA_W          = 12;
  localparam int unsigned MAX_LINE_PIXELS_DEF = 1024;

  localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 12'd768;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } btp_reg_e;

  // per-item control carried from the counter stage to the window stage
  typedef struct packed {
    logic px;     // pixel written into the column (white while flushing)
    logic emit;   // this item produces a result
    logic last;   // result is the final pixel of the frame
    logic xm;     // column to the left is inside the image
    logic x1;     // column to the right is inside
    logic x2;     // column two to the right is inside
    logic ym;     // row above is inside
    logic y1;     // row below is inside
    logic y2;     // row two below is inside
  } btp_tag_t;

endpackage

`default_nettype wire

@@ design/btp_row_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// btp_row_mem
// Line store: three previous rows per column, one read and one write port,
// registered read with write-to-read bypass.
// ----------------------------------------------------------------------------

module btp_row_mem import btp_pkg::*; #(
  parameter  int unsigned Depth = MAX_LINE_PIXELS_DEF,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [2:0]       wdata_i,
  output      logic [2:0]       rdata_o
);

  logic [2:0] mem_q [Depth];
  logic [2:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // same column written back in the cycle it is read again (one-pixel rows)
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/btp_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// btp_ctrl
// Size registers, input and output position counters, result lead-in and
// bounds flags for each item.
// ----------------------------------------------------------------------------

module btp_ctrl import btp_pkg::*; #(
  parameter  int unsigned MaxLinePixels = MAX_LINE_PIXELS_DEF,
  localparam int unsigned AddrW         = $clog2(MaxLinePixels)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  accept_i,
  input  wire logic                  kind_i,
  input  wire logic                  pixel_in_i,
  output      logic                  issue_o,
  output      logic [AddrW-1:0]      addr_o,
  output      btp_tag_t              tag_o
);

  localparam int unsigned WLim  = (MaxLinePixels > 2047) ? 2047 : MaxLinePixels;
  localparam int unsigned KW    = (AddrW > IMG_W_W) ? AddrW : IMG_W_W;
  localparam int unsigned LeadW = $clog2(2 * WLim + 3);
  localparam logic [IMG_W_W-1:0] WLimVal = IMG_W_W'(WLim);

  logic [IMG_W_W-1:0] wreg_q, wreg_d;
  logic [IMG_H_W-1:0] hreg_q, hreg_d;
  logic [AddrW-1:0]   in_col_q, in_col_d;
  logic [IMG_H_W-1:0] in_row_q, in_row_d;
  logic               done_q, done_d;
  logic [LeadW-1:0]   lead_q, lead_d;
  logic [AddrW-1:0]   ox_q, ox_d;
  logic [IMG_H_W-1:0] oy_q, oy_d;

  logic [IMG_W_W-1:0] weff, wlast;
  logic [IMG_H_W-1:0] heff, hlast;
  logic [LeadW-1:0]   target;
  logic               ignore, step, emit, last, col_end, ox_end;

  always_comb begin
    if (wreg_q == '0) begin
      weff = IMG_W_W'(1);
    end else if (wreg_q > WLimVal) begin
      weff = WLimVal;
    end else begin
      weff = wreg_q;
    end
    heff  = (hreg_q == '0) ? IMG_H_W'(1) : hreg_q;
    wlast = weff - IMG_W_W'(1);
    hlast = heff - IMG_H_W'(1);
  end

  assign target  = (LeadW'(weff) << 1) + LeadW'(2);
  assign ignore  = kind_i && !done_q;
  assign step    = accept_i && !ignore;
  assign emit    = (lead_q == target);
  assign col_end = (KW'(in_col_q) == KW'(wlast));
  assign ox_end  = (KW'(ox_q) == KW'(wlast));
  assign last    = emit && ox_end && (oy_q == hlast);

  assign issue_o = step;
  assign addr_o  = in_col_q;

  always_comb begin
    tag_o.px   = pixel_in_i && !done_q;
    tag_o.emit = emit;
    tag_o.last = last;
    tag_o.xm   = (ox_q != '0);
    tag_o.x1   = ((KW+1)'(ox_q) + (KW+1)'(1)) < (KW+1)'(weff);
    tag_o.x2   = ((KW+1)'(ox_q) + (KW+1)'(2)) < (KW+1)'(weff);
    tag_o.ym   = (oy_q != '0);
    tag_o.y1   = ((IMG_H_W+1)'(oy_q) + (IMG_H_W+1)'(1)) < (IMG_H_W+1)'(heff);
    tag_o.y2   = ((IMG_H_W+1)'(oy_q) + (IMG_H_W+1)'(2)) < (IMG_H_W+1)'(heff);
  end

  always_comb begin
    wreg_d   = wreg_q;
    hreg_d   = hreg_q;
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    done_d   = done_q;
    lead_d   = lead_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    if (cfg_we_i) begin
      case (btp_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  wreg_d = cfg_wdata_i[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: hreg_d = cfg_wdata_i[IMG_H_W-1:0];
        default:          wreg_d = wreg_q;
      endcase
      in_col_d = '0;
      in_row_d = '0;
      done_d   = 1'b0;
      lead_d   = '0;
      ox_d     = '0;
      oy_d     = '0;
    end else if (step) begin
      if (col_end) begin
        in_col_d = '0;
        if (!done_q) begin
          if (in_row_q == hlast) begin
            done_d = 1'b1;
          end else begin
            in_row_d = in_row_q + IMG_H_W'(1);
          end
        end
      end else begin
        in_col_d = in_col_q + AddrW'(1);
      end
      if (!emit) begin
        lead_d = lead_q + LeadW'(1);
      end else if (last) begin
        // frame complete: the next item opens a new frame
        in_col_d = '0;
        in_row_d = '0;
        done_d   = 1'b0;
        lead_d   = '0;
        ox_d     = '0;
        oy_d     = '0;
      end else if (ox_end) begin
        ox_d = '0;
        oy_d = oy_q + IMG_H_W'(1);
      end else begin
        ox_d = ox_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wreg_q   <= WIDTH_RESET;
      hreg_q   <= HEIGHT_RESET;
      in_col_q <= '0;
      in_row_q <= '0;
      done_q   <= 1'b0;
      lead_q   <= '0;
      ox_q     <= '0;
      oy_q     <= '0;
    end else begin
      wreg_q   <= wreg_d;
      hreg_q   <= hreg_d;
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      done_q   <= done_d;
      lead_q   <= lead_d;
      ox_q     <= ox_d;
      oy_q     <= oy_d;
    end
  end

endmodule

`default_nettype wire

@@ design/btp_window.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// btp_window
// Column assembly and write-back, 4x4 window, fourteen-template match,
// output register and sticky removal flag.
// ----------------------------------------------------------------------------

module btp_window import btp_pkg::*; #(
  parameter  int unsigned MaxLinePixels = MAX_LINE_PIXELS_DEF,
  localparam int unsigned AddrW         = $clog2(MaxLinePixels)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             issue_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire btp_tag_t         tag_i,
  output      logic             in_ready_o,
  input  wire logic [2:0]       rdata_i,
  output      logic             we_o,
  output      logic [AddrW-1:0] waddr_o,
  output      logic [2:0]       wdata_o,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic             thinned_pixel_o,
  output      logic             removed_o,
  output      logic             last_of_frame_o,
  output      logic             any_removed_o
);

  logic             s1_v_q, s1_v_d;
  btp_tag_t         s1_tag_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [15:0]      win_q, win_new;
  logic             out_v_q, out_v_d;
  logic             fr_q, fr_d;
  logic             thin_q, rem_q, last_q, any_q;
  logic             s1_go, load_out;
  logic [3:0]       col;
  logic             p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
  logic             hit, rem, any;

  assign s1_go      = s1_v_q && (!s1_tag_q.emit || !out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_go;
  assign load_out   = s1_go && s1_tag_q.emit;

  assign col     = {rdata_i, s1_tag_q.px};
  assign win_new = {win_q[11:0], col};
  assign we_o    = s1_go;
  assign waddr_o = s1_addr_q;
  assign wdata_o = col[2:0];

  // bit (2-dx)*4 + (2-dy), masked when the neighbour falls outside the image
  always_comb begin
    p1  = win_new[10];
    p2  = win_new[11] && s1_tag_q.ym;
    p3  = win_new[7]  && s1_tag_q.x1 && s1_tag_q.ym;
    p4  = win_new[6]  && s1_tag_q.x1;
    p5  = win_new[5]  && s1_tag_q.x1 && s1_tag_q.y1;
    p6  = win_new[9]  && s1_tag_q.y1;
    p7  = win_new[13] && s1_tag_q.xm && s1_tag_q.y1;
    p8  = win_new[14] && s1_tag_q.xm;
    p9  = win_new[15] && s1_tag_q.xm && s1_tag_q.ym;
    p10 = win_new[8]  && s1_tag_q.y2;
    p11 = win_new[2]  && s1_tag_q.x2;
  end

  always_comb begin
    hit = ((!p3 || !p5) && !p4 && p2 && p6 && p7 && p8 && p9) ||
          ((!p5 || !p7) && !p6 && p2 && p3 && p4 && p8 && p9) ||
          ((!p7 || !p9) && !p8 && p2 && p3 && p4 && p5 && p6 && p11) ||
          ((!p9 || !p3) && !p2 && p4 && p5 && p6 && p7 && p8 && p10) ||
          (p6 && p8 && !p2 && !p3 && !p4) ||
          (p2 && p3 && p4 && !p6 && !p7 && !p8) ||
          (p2 && p4 && !p3 && !p5 && !p6 && !p7 && !p8 && !p9) ||
          (p2 && p8 && !p4 && !p5 && !p6) ||
          (p4 && p5 && p6 && !p8 && !p9 && !p2) ||
          (p4 && p6 && !p2 && !p3 && !p5 && !p7 && !p8 && !p9) ||
          (p5 && p6 && p7 && !p2 && !p3 && !p4 && !p8 && !p9) ||
          (p7 && p8 && p9 && !p2 && !p3 && !p4 && !p5 && !p6) ||
          (p2 && p3 && p9 && !p4 && !p5 && !p6 && !p7 && !p8) ||
          (p3 && p4 && p5 && !p6 && !p7 && !p8 && !p9 && !p2);
    rem = p1 && hit;
    any = fr_q || rem;
  end

  always_comb begin
    s1_v_d = s1_v_q;
    if (in_ready_o) begin
      s1_v_d = issue_i;
    end
    out_v_d = out_v_q;
    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end
    if (load_out) begin
      out_v_d = 1'b1;
    end
    fr_d = fr_q;
    if (cfg_we_i) begin
      fr_d = 1'b0;
    end else if (load_out) begin
      fr_d = s1_tag_q.last ? 1'b0 : any;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      fr_q    <= 1'b0;
      win_q   <= '0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
      fr_q    <= fr_d;
      if (s1_go) begin
        win_q <= win_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      s1_tag_q  <= tag_i;
      s1_addr_q <= addr_i;
    end
    if (load_out) begin
      thin_q <= p1 && !rem;
      rem_q  <= rem;
      last_q <= s1_tag_q.last;
      any_q  <= any;
    end
  end

  assign out_valid_o     = out_v_q;
  assign thinned_pixel_o = thin_q;
  assign removed_o       = rem_q;
  assign last_of_frame_o = last_q;
  assign any_removed_o   = any_q;

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_go) |=> (s1_v_q && $stable(s1_tag_q) && $stable(s1_addr_q)))
    else $error("window stage lost a stalled item");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_v_q && !out_ready_i && s1_tag_q.emit))
    else $error("input held off without a blocked result");

  a_removed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && rem_q) |-> (any_q && !thin_q))
    else $error("removed pixel not reflected in flags");

  a_flag_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && s1_tag_q.last) |=> !fr_q)
    else $error("removal flag survived end of frame");

endmodule

`default_nettype wire

@@ design/binary_thinning_pass_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// binary_thinning_pass_core
// One parallel thinning pass over a raster-order binary image stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one item per transfer: a pixel
// (kind_i = 0) or a flush item (kind_i = 1). Output channel
// (out_valid_o/out_ready_i) carries the thinned pixels in raster order.
// One item is accepted per cycle while in_ready_o is high. A result trails its
// pixel by 2*W+2 items (W the effective row width), then passes the line store
// read and the output register. After the last pixel of a frame, 2*W+2
// flush items drive out the remaining results; last_of_frame_o marks the
// final one and the counters restart for the next frame.
// The line store is a single-port-read, single-port-write memory of
// MAX_LINE_PIXELS x 3 bits, read when an item is accepted and written back
// as that item leaves the window stage; its contents are never cleared,
// since unwritten rows are always outside the image and masked.
// Reset clears the counters, the removal flag and the window and sets the
// size registers to 1024 x 768. A write to either size register restarts
// the frame. When the receiver stalls, one result waits in the output
// register and one item in the window stage; in_ready_o drops only once an
// item with a result is held behind a full output register.
// ----------------------------------------------------------------------------

module binary_thinning_pass_core import btp_pkg::*; #(
  parameter int unsigned MAX_LINE_PIXELS = MAX_LINE_PIXELS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic                  kind_i,
  input  wire logic                  pixel_in_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic                  thinned_pixel_o,
  output      logic                  removed_o,
  output      logic                  last_of_frame_o,
  output      logic                  any_removed_o
);

  localparam int unsigned AddrW = $clog2(MAX_LINE_PIXELS);

  logic             accept, issue;
  logic [AddrW-1:0] addr;
  btp_tag_t         tag;
  logic [2:0]       rdata;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [2:0]       wdata;

  assign accept = in_valid_i && in_ready_o;

  btp_ctrl #(
    .MaxLinePixels(MAX_LINE_PIXELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .kind_i      (kind_i),
    .pixel_in_i  (pixel_in_i),
    .issue_o     (issue),
    .addr_o      (addr),
    .tag_o       (tag)
  );

  btp_row_mem #(
    .Depth(MAX_LINE_PIXELS)
  ) u_row_mem (
    .clk_i   (clk_i),
    .re_i    (issue),
    .raddr_i (addr),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  btp_window #(
    .MaxLinePixels(MAX_LINE_PIXELS)
  ) u_window (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .issue_i         (issue),
    .addr_i          (addr),
    .tag_i           (tag),
    .in_ready_o      (in_ready_o),
    .rdata_i         (rdata),
    .we_o            (we),
    .waddr_o         (waddr),
    .wdata_o         (wdata),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .thinned_pixel_o (thinned_pixel_o),
    .removed_o       (removed_o),
    .last_of_frame_o (last_of_frame_o),
    .any_removed_o   (any_removed_o)
  );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary thinning pass core. A table of directed
// items on a 1x1 image comes first, then random frames of mostly small sizes
// and a few extreme sizes. A predictor of the pass follows every accepted
// item and queues the pixel it expects; each output item is checked field
// by field against the oldest entry. Sender and receiver idle at random in
// several phases, and in some frames the receiver is held off for long.
// ----------------------------------------------------------------------------

module tb_top;
  import btp_pkg::*;

  localparam int unsigned LINE_MAX      = MAX_LINE_PIXELS_DEF;
  localparam int          LINE_AW       = $clog2(LINE_MAX);
  localparam int          RANDOM_ITEMS  = 1400;
  localparam int          EXTREME_CAP   = 64;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          END_WAIT      = 50000;
  localparam int          MAX_REPORTS   = 60;
  localparam int unsigned LIMIT_CYCLES  = 1000000;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } item_kind_e;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // field order matches the output ports
  typedef struct packed {
    logic thinned;
    logic removed;
    logic frame_end;
    logic any_gone;
  } thin_res_t;

  typedef struct packed {
    item_kind_e knd;
    logic       pix;
    logic       typed;
    thin_res_t  want;
  } dir_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic                  cfg_idx_i   = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  kind_i      = 1'b0;
  logic                  pixel_in_i  = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  thinned_pixel_o;
  logic                  removed_o;
  logic                  last_of_frame_o;
  logic                  any_removed_o;

  binary_thinning_pass_core #(
    .MAX_LINE_PIXELS (LINE_MAX)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .pixel_in_i      (pixel_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .thinned_pixel_o (thinned_pixel_o),
    .removed_o       (removed_o),
    .last_of_frame_o (last_of_frame_o),
    .any_removed_o   (any_removed_o)
  );

  // predictor state
  logic [2:0]      line_mem [LINE_MAX];
  logic [15:0]     win16        = '0;
  int unsigned     in_col       = 0;
  int unsigned     in_row       = 0;
  int unsigned     out_pos      = 0;
  logic            removed_seen = 1'b0;
  logic [10:0]     reg_w        = WIDTH_RESET;
  logic [11:0]     reg_h        = HEIGHT_RESET;

  thin_res_t       pending_px [$];
  thin_res_t       predicted;
  thin_res_t       want_px;

  // typed expectation travelling with the item on offer
  logic            note_typed = 1'b0;
  thin_res_t       note_res   = '0;

  int              src_pct    = 0;
  int              snk_pct    = 0;
  logic            hold_arm   = 1'b0;
  logic            hold_taken = 1'b0;
  int              hold_left  = 0;
  int              fail_cnt   = 0;
  int unsigned     cycle_cnt  = 0;

  dir_row_t        dir_rows [$];
  logic [22:0]     extreme_sizes [$];

  function automatic int unsigned eff_width(input logic [10:0] raw);
    if (raw == '0) return 1;
    if (raw > LINE_MAX) return LINE_MAX;
    return 32'(raw);
  endfunction

  function automatic int unsigned eff_height(input logic [11:0] raw);
    return (raw == '0) ? 1 : 32'(raw);
  endfunction

  function automatic void clear_frame();
    in_col       = 0;
    in_row       = 0;
    out_pos      = 0;
    removed_seen = 1'b0;
  endfunction

  // pixel at (dx,dy) from the centre; outside the image reads white
  function automatic logic win_at(input int dx, input int dy, input int ox, input int oy,
                                  input int w, input int h);
    int x, y;
    x = ox + dx;
    y = oy + dy;
    if (x < 0 || x >= w || y < 0 || y >= h) return 1'b0;
    return win16[4'((2 - dx) * 4 + (2 - dy))];
  endfunction

  function automatic bit thin_step(input logic knd, input logic pix, output thin_res_t res);
    int unsigned w, h, n, m, ox, oy;
    logic [3:0] col;
    logic px, fin, hit, rem;
    logic p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    w   = eff_width(reg_w);
    h   = eff_height(reg_h);
    res = '0;
    fin = (in_row >= h);
    if (knd == KIND_FLUSH && !fin) return 1'b0;
    px = fin ? 1'b0 : pix;
    n  = in_row * w + in_col;

    col                          = {line_mem[LINE_AW'(in_col)], px};
    line_mem[LINE_AW'(in_col)]   = col[2:0];
    win16                        = {win16[11:0], col};
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (n < 2 * w + 2) return 1'b0;

    m   = out_pos;
    ox  = m % w;
    oy  = m / w;
    p1  = win_at(0, 0, ox, oy, w, h);
    p2  = win_at(0, -1, ox, oy, w, h);
    p3  = win_at(1, -1, ox, oy, w, h);
    p4  = win_at(1, 0, ox, oy, w, h);
    p5  = win_at(1, 1, ox, oy, w, h);
    p6  = win_at(0, 1, ox, oy, w, h);
    p7  = win_at(-1, 1, ox, oy, w, h);
    p8  = win_at(-1, 0, ox, oy, w, h);
    p9  = win_at(-1, -1, ox, oy, w, h);
    p10 = win_at(0, 2, ox, oy, w, h);
    p11 = win_at(2, 0, ox, oy, w, h);

    hit = ((!p3 || !p5) && !p4 && p2 && p6 && p7 && p8 && p9) ||
          ((!p5 || !p7) && !p6 && p2 && p3 && p4 && p8 && p9) ||
          ((!p7 || !p9) && !p8 && p2 && p3 && p4 && p5 && p6 && p11) ||
          ((!p9 || !p3) && !p2 && p4 && p5 && p6 && p7 && p8 && p10) ||
          (p6 && p8 && !p2 && !p3 && !p4) ||
          (p2 && p3 && p4 && !p6 && !p7 && !p8) ||
          (p2 && p4 && !p3 && !p5 && !p6 && !p7 && !p8 && !p9) ||
          (p2 && p8 && !p4 && !p5 && !p6) ||
          (p4 && p5 && p6 && !p8 && !p9 && !p2) ||
          (p4 && p6 && !p2 && !p3 && !p5 && !p7 && !p8 && !p9) ||
          (p5 && p6 && p7 && !p2 && !p3 && !p4 && !p8 && !p9) ||
          (p7 && p8 && p9 && !p2 && !p3 && !p4 && !p5 && !p6) ||
          (p2 && p3 && p9 && !p4 && !p5 && !p6 && !p7 && !p8) ||
          (p3 && p4 && p5 && !p6 && !p7 && !p8 && !p9 && !p2);

    rem = p1 && hit;
    if (rem) removed_seen = 1'b1;
    res.thinned  = p1 && !rem;
    res.removed  = rem;
    res.any_gone = removed_seen;
    if (m + 1 >= w * h) begin
      res.frame_end = 1'b1;
      clear_frame();
    end else begin
      out_pos = m + 1;
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string label, input logic want, input logic got);
    if (got !== want) begin
      if (fail_cnt < MAX_REPORTS)
        $display("%0t: %s expected %0b got %0b", $time, label, want, got);
      fail_cnt++;
    end
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("%0t: run exceeded %0d cycles", $time, LIMIT_CYCLES);
      $display("Test completed with failures");
      $finish;
    end
  end

  // configuration writes and accepted items feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (btp_reg_e'(cfg_idx_i) == REG_IMAGE_WIDTH) reg_w = cfg_wdata_i[10:0];
        else reg_h = cfg_wdata_i;
        clear_frame();
      end
      if (in_valid_i && in_ready_o) begin
        if (thin_step(kind_i, pixel_in_i, predicted))
          pending_px.push_back(note_typed ? note_res : predicted);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_px.size() == 0) begin
        if (fail_cnt < MAX_REPORTS)
          $display("%0t: expected no item, got thinned %0b removed %0b last %0b any %0b",
                   $time, thinned_pixel_o, removed_o, last_of_frame_o, any_removed_o);
        fail_cnt++;
      end else begin
        want_px = pending_px.pop_front();
        check_field("thinned_pixel", want_px.thinned, thinned_pixel_o);
        check_field("removed", want_px.removed, removed_o);
        check_field("last_of_frame", want_px.frame_end, last_of_frame_o);
        check_field("any_removed", want_px.any_gone, any_removed_o);
      end
    end
  end

  // receiver: random stalls, plus one long hold each time it is armed
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_arm && !hold_taken) begin
      hold_left   <= HOLD_CYCLES;
      hold_taken  <= 1'b1;
      out_ready_i <= 1'b0;
    end else begin
      if (!hold_arm) hold_taken <= 1'b0;
      out_ready_i <= ($urandom_range(99) >= snk_pct);
    end
  end

  task automatic set_mode(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        src_pct = 0;
        snk_pct <= 0;
      end
      IDLE_SENDER: begin
        src_pct = 61;
        snk_pct <= 0;
      end
      IDLE_RECEIVER: begin
        src_pct = 0;
        snk_pct <= 61;
      end
      default: begin
        src_pct = 26;
        snk_pct <= 26;
      end
    endcase
  endtask

  task automatic send_item(input item_kind_e knd, input logic pix, input logic typed,
                           input thin_res_t res);
    if (src_pct != 0 && $urandom_range(99) < src_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= knd;
    pixel_in_i <= pix;
    note_typed <= typed;
    note_res   <= res;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // block drained: nothing expected and the window stage given time to settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_sizes(input logic do_w, input logic [10:0] w_raw,
                           input logic do_h, input logic [11:0] h_raw);
    logic top_bit;
    top_bit = 1'($urandom_range(1));
    if (do_w) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= REG_IMAGE_WIDTH;
      cfg_wdata_i <= {top_bit, w_raw};  // bit 11 is unused by the width
      @(posedge clk_i);
    end
    if (do_h) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= REG_IMAGE_HEIGHT;
      cfg_wdata_i <= h_raw;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // pixels with the odd early flush, then trailing items, some of them surplus pixels
  task automatic play_frame(input int px_total, input int flush_total, input int pct_black);
    logic pix;
    for (int i = 0; i < px_total; i++) begin
      if ($urandom_range(19) == 0) begin
        pix = 1'($urandom_range(1));
        send_item(KIND_FLUSH, pix, 1'b0, '0);
      end
      pix = ($urandom_range(99) < pct_black);
      send_item(KIND_PIXEL, pix, 1'b0, '0);
    end
    for (int i = 0; i < flush_total; i++) begin
      pix = 1'($urandom_range(1));
      if ($urandom_range(4) == 0) send_item(KIND_PIXEL, pix, 1'b0, '0);
      else send_item(KIND_FLUSH, pix, 1'b0, '0);
    end
  endtask

  initial begin
    int          frame_no;
    int          items_sent;
    int          px_total;
    int          flush_total;
    int          waited;
    int unsigned w;
    int unsigned h;
    logic [10:0] cur_w;
    logic [11:0] cur_h;
    logic [10:0] new_w;
    logic [11:0] new_h;
    logic        do_w;
    logic        do_h;
    logic        restart_due;
    logic        pressure;
    logic        pix;

    foreach (line_mem[i]) line_mem[i] = 3'b000;

    // 1x1 image: results trail by four items; thinned/removed/last/any
    dir_rows = '{
      {KIND_FLUSH, 1'b0, 1'b0, thin_res_t'(4'b0000)},  // early flush, ignored
      {KIND_PIXEL, 1'b1, 1'b0, thin_res_t'(4'b0000)},
      {KIND_FLUSH, 1'b0, 1'b0, thin_res_t'(4'b0000)},
      {KIND_PIXEL, 1'b1, 1'b0, thin_res_t'(4'b0000)},  // surplus pixel acts as flush
      {KIND_FLUSH, 1'b1, 1'b0, thin_res_t'(4'b0000)},
      {KIND_FLUSH, 1'b0, 1'b1, thin_res_t'(4'b1010)},  // lone black pixel survives
      {KIND_FLUSH, 1'b1, 1'b0, thin_res_t'(4'b0000)},  // new frame, ignored
      {KIND_PIXEL, 1'b0, 1'b0, thin_res_t'(4'b0000)},
      {KIND_PIXEL, 1'b0, 1'b0, thin_res_t'(4'b0000)},
      {KIND_FLUSH, 1'b0, 1'b0, thin_res_t'(4'b0000)},
      {KIND_FLUSH, 1'b0, 1'b0, thin_res_t'(4'b0000)},
      {KIND_FLUSH, 1'b0, 1'b1, thin_res_t'(4'b0010)},
      {KIND_PIXEL, 1'b1, 1'b0, thin_res_t'(4'b0000)}   // left open, restarted by a write
    };

    // width above the line store, zero sizes and the largest height
    extreme_sizes = '{
      {11'd0, 12'd0},
      {11'd2047, 12'd1},
      {11'd1, 12'd4095},
      {11'd1024, 12'd2},
      {11'd3, 12'd0},
      {11'd0, 12'd5}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_mode(IDLE_NONE);
    set_sizes(1'b1, 11'd1, 1'b1, 12'd1);
    foreach (dir_rows[i])
      send_item(dir_rows[i].knd, dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].want);

    cur_w       = 11'd1;
    cur_h       = 12'd1;
    restart_due = 1'b1;
    frame_no    = 0;
    items_sent  = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pressure = (frame_no % 11 == 6);
      set_mode(pressure ? IDLE_NONE : idle_mode_e'(frame_no % 4));
      if (pressure) begin
        new_w = 11'($urandom_range(2, 6));
        new_h = 12'($urandom_range(3, 6));
      end else begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4:  new_w = 11'($urandom_range(9, 32));
          5:              new_w = 11'($urandom_range(33, 128));
          default:        new_w = 11'($urandom_range(1, 8));
        endcase
        new_h = (new_w > 32) ? 12'($urandom_range(1, 3)) : 12'($urandom_range(1, 10));
      end
      do_w = restart_due || new_w != cur_w || $urandom_range(3) == 0;
      do_h = new_h != cur_h || $urandom_range(3) == 0;
      if (do_w || do_h) begin
        wait_idle();
        set_sizes(do_w, new_w, do_h, new_h);
        cur_w = new_w;
        cur_h = new_h;
      end
      w           = eff_width(cur_w);
      h           = eff_height(cur_h);
      px_total    = w * h;
      flush_total = 2 * w + 2;
      restart_due = 1'b0;
      // now and then a frame is cut short and restarted by the next write
      if (!pressure && $urandom_range(9) == 0) begin
        px_total    = $urandom_range(px_total - 1);
        flush_total = 0;
        restart_due = 1'b1;
      end
      hold_arm <= pressure;
      play_frame(px_total, flush_total, $urandom_range(20, 95));
      hold_arm <= 1'b0;
      if ($urandom_range(7) == 0) begin
        pix = 1'($urandom_range(1));
        send_item(KIND_FLUSH, pix, 1'b0, '0);
      end
      items_sent += px_total + flush_total;
      frame_no++;
    end

    foreach (extreme_sizes[i]) begin
      set_mode(idle_mode_e'(i % 4));
      wait_idle();
      set_sizes(1'b1, extreme_sizes[i][22:12], 1'b1, extreme_sizes[i][11:0]);
      w           = eff_width(extreme_sizes[i][22:12]);
      h           = eff_height(extreme_sizes[i][11:0]);
      px_total    = w * h;
      flush_total = 2 * w + 2;
      // large frames are only begun; the next write restarts them
      if (px_total + flush_total > EXTREME_CAP) begin
        px_total    = EXTREME_CAP;
        flush_total = 0;
      end
      play_frame(px_total, flush_total, 50);
    end

    in_valid_i <= 1'b0;
    waited = 0;
    @(posedge clk_i);
    while (pending_px.size() != 0 && waited < END_WAIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_px.size() != 0) begin
      $display("%0t: expected %0d more items, got none", $time, pending_px.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
